>>> rtl/qpsam_pkg.sv
// Shared types, widths and width helpers for the pose to affine matrix pipeline.
// Used by the rotation front end, the top level and the port checker.
`default_nettype none

package qpsam_pkg;

    localparam int QUAT_W = 14;
    localparam int WORD_W = 32;

    // Slots of the rotation matrix, column-major as the results are listed
    localparam int R00 = 0;
    localparam int R01 = 1;
    localparam int R02 = 2;
    localparam int R10 = 3;
    localparam int R11 = 4;
    localparam int R12 = 5;
    localparam int R20 = 6;
    localparam int R21 = 7;
    localparam int R22 = 8;
    localparam int ROT_N = 9;

    // Width of a doubled component product after the fractional shift
    function automatic int dp_width(input int frac);
        return 2 * QUAT_W - (frac - 1);
    endfunction

    // Width of a rotation entry: room for one, two doubled terms and sign
    function automatic int rot_width(input int frac);
        int base;
        base = (dp_width(frac) > frac + 2) ? dp_width(frac) : frac + 2;
        return base + 2;
    endfunction

    // Stage advance strobes for the rotation front end
    typedef struct packed {
        logic s1;
        logic s2;
    } qpsam_adv_t;

endpackage

`default_nettype wire

>>> rtl/qpsam_rotate.sv
// Rotation front end: doubled quaternion products (stage 1) and the 3x3
// rotation entries (stage 2). Depends on qpsam_pkg.
`default_nettype none

module qpsam_rotate #(
    parameter int FRAC_BITS = 12
) (
    input  wire                                   clk,
    input  wire qpsam_pkg::qpsam_adv_t            adv,
    input  wire signed [qpsam_pkg::QUAT_W-1:0]    quat_w,
    input  wire signed [qpsam_pkg::QUAT_W-1:0]    quat_x,
    input  wire signed [qpsam_pkg::QUAT_W-1:0]    quat_y,
    input  wire signed [qpsam_pkg::QUAT_W-1:0]    quat_z,
    output logic signed [qpsam_pkg::rot_width(FRAC_BITS)-1:0] rot [qpsam_pkg::ROT_N]
);
    import qpsam_pkg::*;

    localparam int DP_W   = dp_width(FRAC_BITS);
    localparam int ROT_W  = rot_width(FRAC_BITS);
    localparam int PROD_W = 2 * QUAT_W;
    localparam logic signed [ROT_W-1:0] ONE_FX = ROT_W'(1) << FRAC_BITS;

    logic signed [DP_W-1:0] wx_reg, wy_reg, wz_reg, xx_reg, xy_reg;
    logic signed [DP_W-1:0] xz_reg, yy_reg, yz_reg, zz_reg;
    logic signed [DP_W-1:0] wx_next, wy_next, wz_next, xx_next, xy_next;
    logic signed [DP_W-1:0] xz_next, yy_next, yz_next, zz_next;

    logic signed [ROT_W-1:0] wx_e, wy_e, wz_e, xx_e, xy_e, xz_e, yy_e, yz_e, zz_e;
    logic signed [ROT_W-1:0] rot_reg  [ROT_N];
    logic signed [ROT_W-1:0] rot_next [ROT_N];

    function automatic logic signed [DP_W-1:0] dbl_mul(
        input logic signed [QUAT_W-1:0] a,
        input logic signed [QUAT_W-1:0] b
    );
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] s;
        p = PROD_W'(a) * PROD_W'(b);
        s = p >>> (FRAC_BITS - 1);
        return s[DP_W-1:0];
    endfunction

    always_comb
    begin
        wx_next = dbl_mul(quat_w, quat_x);
        wy_next = dbl_mul(quat_w, quat_y);
        wz_next = dbl_mul(quat_w, quat_z);
        xx_next = dbl_mul(quat_x, quat_x);
        xy_next = dbl_mul(quat_x, quat_y);
        xz_next = dbl_mul(quat_x, quat_z);
        yy_next = dbl_mul(quat_y, quat_y);
        yz_next = dbl_mul(quat_y, quat_z);
        zz_next = dbl_mul(quat_z, quat_z);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            wx_reg <= wx_next;
            wy_reg <= wy_next;
            wz_reg <= wz_next;
            xx_reg <= xx_next;
            xy_reg <= xy_next;
            xz_reg <= xz_next;
            yy_reg <= yy_next;
            yz_reg <= yz_next;
            zz_reg <= zz_next;
        end
    end

    // sign-extend the products to entry width before combining
    always_comb
    begin
        wx_e = ROT_W'(wx_reg);
        wy_e = ROT_W'(wy_reg);
        wz_e = ROT_W'(wz_reg);
        xx_e = ROT_W'(xx_reg);
        xy_e = ROT_W'(xy_reg);
        xz_e = ROT_W'(xz_reg);
        yy_e = ROT_W'(yy_reg);
        yz_e = ROT_W'(yz_reg);
        zz_e = ROT_W'(zz_reg);
        rot_next[R00] = ONE_FX - yy_e - zz_e;
        rot_next[R01] = xy_e + wz_e;
        rot_next[R02] = xz_e - wy_e;
        rot_next[R10] = xy_e - wz_e;
        rot_next[R11] = ONE_FX - xx_e - zz_e;
        rot_next[R12] = yz_e + wx_e;
        rot_next[R20] = xz_e + wy_e;
        rot_next[R21] = yz_e - wx_e;
        rot_next[R22] = ONE_FX - xx_e - yy_e;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            rot_reg <= rot_next;
        end
    end

    assign rot = rot_reg;

endmodule

`default_nettype wire

>>> rtl/quat_pos_scale_to_affine_matrix.sv
// Joint pose (quaternion, translation, per-axis scale) to 4x3 affine matrix.
// Top level of the pipeline; uses qpsam_pkg and qpsam_rotate.
//
// Usage:
//   Input channel: in_valid/in_stall carry one pose per beat: quat_w..quat_z
//   (signed 1.FRAC_BITS), pos_x..pos_z and scale_x..scale_z (signed 32-bit
//   fixed point). Output channel: out_valid/out_stall carry the twelve words
//   m00..m22 and t0..t2 of the matching matrix.
//   Stage 1 forms the nine doubled products, stage 2 the rotation entries,
//   stage 3 multiplies each column by its scale into the output register.
//   Throughput is one pose per cycle while out_stall is low; the scale
//   multipliers of stage 3 are the longest path.
//   Reset clears the stage valid bits only; no beat is shown after reset until
//   a pose has gone through.
//   When out_stall is high the output holds; earlier stages keep filling any
//   empty slot, and in_stall rises only once all three stages hold poses.
`default_nettype none

module quat_pos_scale_to_affine_matrix #(
    parameter int FRAC_BITS = 12
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire signed [qpsam_pkg::QUAT_W-1:0]   quat_w,
    input  wire signed [qpsam_pkg::QUAT_W-1:0]   quat_x,
    input  wire signed [qpsam_pkg::QUAT_W-1:0]   quat_y,
    input  wire signed [qpsam_pkg::QUAT_W-1:0]   quat_z,
    input  wire signed [qpsam_pkg::WORD_W-1:0]   pos_x,
    input  wire signed [qpsam_pkg::WORD_W-1:0]   pos_y,
    input  wire signed [qpsam_pkg::WORD_W-1:0]   pos_z,
    input  wire signed [qpsam_pkg::WORD_W-1:0]   scale_x,
    input  wire signed [qpsam_pkg::WORD_W-1:0]   scale_y,
    input  wire signed [qpsam_pkg::WORD_W-1:0]   scale_z,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic signed [qpsam_pkg::WORD_W-1:0]  m00,
    output logic signed [qpsam_pkg::WORD_W-1:0]  m01,
    output logic signed [qpsam_pkg::WORD_W-1:0]  m02,
    output logic signed [qpsam_pkg::WORD_W-1:0]  m10,
    output logic signed [qpsam_pkg::WORD_W-1:0]  m11,
    output logic signed [qpsam_pkg::WORD_W-1:0]  m12,
    output logic signed [qpsam_pkg::WORD_W-1:0]  m20,
    output logic signed [qpsam_pkg::WORD_W-1:0]  m21,
    output logic signed [qpsam_pkg::WORD_W-1:0]  m22,
    output logic signed [qpsam_pkg::WORD_W-1:0]  t0,
    output logic signed [qpsam_pkg::WORD_W-1:0]  t1,
    output logic signed [qpsam_pkg::WORD_W-1:0]  t2
);
    import qpsam_pkg::*;

    localparam int ROT_W  = rot_width(FRAC_BITS);
    localparam int PROD_W = ROT_W + WORD_W;

    logic       v1_reg, v2_reg, v3_reg;
    logic       adv3;
    qpsam_adv_t adv;

    logic signed [WORD_W-1:0] sx1_reg, sy1_reg, sz1_reg;
    logic signed [WORD_W-1:0] sx2_reg, sy2_reg, sz2_reg;
    logic signed [WORD_W-1:0] px1_reg, py1_reg, pz1_reg;
    logic signed [WORD_W-1:0] px2_reg, py2_reg, pz2_reg;
    logic signed [WORD_W-1:0] px3_reg, py3_reg, pz3_reg;

    logic signed [ROT_W-1:0]  rot [ROT_N];
    logic signed [WORD_W-1:0] col_scale [ROT_N];
    logic signed [WORD_W-1:0] m_reg  [ROT_N];
    logic signed [WORD_W-1:0] m_next [ROT_N];
    logic signed [PROD_W-1:0] prod   [ROT_N];

    // advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        adv3   = !v3_reg || !out_stall;
        adv.s2 = !v2_reg || adv3;
        adv.s1 = !v1_reg || adv.s2;
    end

    assign in_stall = !adv.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv.s1)
            begin
                v1_reg <= in_valid;
            end
            if (adv.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    qpsam_rotate #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rotate (
        .clk    (clk),
        .adv    (adv),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .rot    (rot)
    );

    // scales and translation ride alongside the rotation stages
    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            sx1_reg <= scale_x;
            sy1_reg <= scale_y;
            sz1_reg <= scale_z;
            px1_reg <= pos_x;
            py1_reg <= pos_y;
            pz1_reg <= pos_z;
        end
        if (adv.s2)
        begin
            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;
            sz2_reg <= sz1_reg;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            pz2_reg <= pz1_reg;
        end
        if (adv3)
        begin
            px3_reg <= px2_reg;
            py3_reg <= py2_reg;
            pz3_reg <= pz2_reg;
            m_reg   <= m_next;
        end
    end

    always_comb
    begin
        col_scale[R00] = sx2_reg;
        col_scale[R01] = sx2_reg;
        col_scale[R02] = sx2_reg;
        col_scale[R10] = sy2_reg;
        col_scale[R11] = sy2_reg;
        col_scale[R12] = sy2_reg;
        col_scale[R20] = sz2_reg;
        col_scale[R21] = sz2_reg;
        col_scale[R22] = sz2_reg;
    end

    // floor shift by FRAC_BITS and wrap to a word is a plain slice
    always_comb
    begin
        for (int i = 0; i < ROT_N; i++)
        begin
            prod[i]   = PROD_W'(rot[i]) * PROD_W'(col_scale[i]);
            m_next[i] = prod[i][FRAC_BITS +: WORD_W];
        end
    end

    assign out_valid = v3_reg;
    assign m00 = m_reg[R00];
    assign m01 = m_reg[R01];
    assign m02 = m_reg[R02];
    assign m10 = m_reg[R10];
    assign m11 = m_reg[R11];
    assign m12 = m_reg[R12];
    assign m20 = m_reg[R20];
    assign m21 = m_reg[R21];
    assign m22 = m_reg[R22];
    assign t0  = px3_reg;
    assign t1  = py3_reg;
    assign t2  = pz3_reg;

endmodule

`default_nettype wire

>>> rtl/qpsam_checker.sv
// Port-level checks for the pose to affine matrix pipeline, bound to the top.
// Depends on qpsam_pkg for word widths.
`default_nettype none

module qpsam_checker (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 in_valid,
    input wire                                 in_stall,
    input wire                                 out_valid,
    input wire                                 out_stall,
    input wire signed [qpsam_pkg::WORD_W-1:0]  m00,
    input wire signed [qpsam_pkg::WORD_W-1:0]  m11,
    input wire signed [qpsam_pkg::WORD_W-1:0]  m22,
    input wire signed [qpsam_pkg::WORD_W-1:0]  t0,
    input wire signed [qpsam_pkg::WORD_W-1:0]  t1,
    input wire signed [qpsam_pkg::WORD_W-1:0]  t2
);
    import qpsam_pkg::*;

    // input backs up only when the output is full and held
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("in_stall raised while output can drain");

    // an accepted pose reaches the output when out_stall stays low while it passes through
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("accepted pose did not reach the output in time");

    // a held beat keeps its diagonal and translation words
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(m00) && $stable(m11)
            && $stable(m22) && $stable(t0) && $stable(t1) && $stable(t2))
        else $error("stalled output beat changed");

    // valid drops only after a beat was taken
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("out_valid dropped without a beat");

endmodule

bind quat_pos_scale_to_affine_matrix qpsam_checker u_qpsam_checker (.*);

`default_nettype wire
